>>> sv/page_replacement_unit_assert.svh
// ---------------------------------------------------------------------------
// page_replacement_unit_assert.svh
// Assertion macros for the page replacement unit, switched off by ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define PAGE_REPLACEMENT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// holds in every cycle outside reset
`define PRU_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PRU_ASSERT(lbl, expr, msg)
`define PRU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/pru_pkg.sv
// ---------------------------------------------------------------------------
// pru_pkg
// Policy codes, register indexes and fixed widths of the page replacement unit.
// ---------------------------------------------------------------------------
package pru_pkg;

    localparam int POLICY_W    = 2;
    localparam int FRAMES_W    = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int EVICT_W     = 16;
    localparam int COUNT_W     = 32;

    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LRU  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_SC   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd1;

    localparam logic [POLICY_W-1:0] POLICY_RESET = POL_FIFO;
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 4'd4;

endpackage

>>> sv/page_replacement_unit.sv
// ---------------------------------------------------------------------------
// page_replacement_unit
// Frame table with FIFO, LRU and second chance replacement; reports fault,
// evicted page and a saturating fault count for each page reference.
// ---------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        in         in_valid / in_stall    page
// out       out        out_valid / out_stall  fault, evicted_valid,
//                                             evicted_page, fault_count
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each item passes the input
// register, then table lookup and update into the result register.
// The table search, victim select and update all fit in that one stage.
// A stalled result holds and the input register stalls behind it.
// Reset and any write to a listed register clear the table and the count.
// ---------------------------------------------------------------------------
`include "page_replacement_unit_assert.svh"

module page_replacement_unit
    import pru_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PAGE_BITS-1:0]  page,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  fault,
    output logic                  evicted_valid,
    output logic [EVICT_W-1:0]    evicted_page,
    output logic [COUNT_W-1:0]    fault_count,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int RANK_W = IDX_W;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [RANK_W-1:0]    rank_t;

    // configuration
    logic [POLICY_W-1:0] policy_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic                cfg_we;
    logic                cfg_clear;

    // frame table
    page_t               fp_reg   [MAX_FRAMES];
    page_t               fp_next  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] fv_reg;
    logic [MAX_FRAMES-1:0] fv_next;
    logic [MAX_FRAMES-1:0] rb_reg;
    logic [MAX_FRAMES-1:0] rb_next;
    rank_t               rk_reg   [MAX_FRAMES];
    rank_t               rk_next  [MAX_FRAMES];
    logic [COUNT_W-1:0]  total_reg;
    logic [COUNT_W-1:0]  total_next;

    // input stage
    logic                s1_valid_reg;
    page_t               s1_page_reg;
    logic                in_accept;
    logic                out_free;
    logic                s1_adv;

    // result stage
    logic                out_valid_reg;
    logic                fault_reg;
    logic                evv_reg;
    logic [EVICT_W-1:0]  evp_reg;
    logic [COUNT_W-1:0]  cnt_reg;

    // lookup
    logic [CNT_W-1:0]    n_act;
    logic [IDX_W-1:0]    nm1;
    logic                is_lru;
    logic                is_sc;
    logic                hit_found;
    logic [IDX_W-1:0]    hit_idx;
    logic                inv_found;
    logic [IDX_W-1:0]    inv_idx;
    logic                clr_found;
    logic [IDX_W-1:0]    clr_idx;
    logic [IDX_W-1:0]    lru_idx;
    logic [IDX_W-1:0]    victim;
    logic                ev_valid;
    logic [EVICT_W-1:0]  ev_page;
    rank_t               hit_rank;
    logic                sc_clear;
    logic                sc_clear_all;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_clear = cfg_we && (cfg_index == REG_POLICY || cfg_index == REG_FRAMES);

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    assign out_valid     = out_valid_reg;
    assign fault         = fault_reg;
    assign evicted_valid = evv_reg;
    assign evicted_page  = evp_reg;
    assign fault_count   = cnt_reg;

    assign is_lru = (policy_reg == POL_LRU);
    assign is_sc  = (policy_reg == POL_SC);

    always_comb
    begin
        if (frames_reg == '0)
            n_act = CNT_W'(1);
        else if (32'(frames_reg) > MAX_FRAMES)
            n_act = CNT_W'(MAX_FRAMES);
        else
            n_act = CNT_W'(frames_reg);
        nm1 = IDX_W'(n_act - CNT_W'(1));
    end

    // searches over the active frames
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        inv_found = 1'b0;
        inv_idx   = '0;
        clr_found = 1'b0;
        clr_idx   = '0;
        lru_idx   = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (CNT_W'(i) < n_act)
            begin
                if (!hit_found && fv_reg[i] && fp_reg[i] == s1_page_reg)
                begin
                    hit_found = 1'b1;
                    hit_idx   = IDX_W'(i);
                end
                if (!inv_found && !fv_reg[i])
                begin
                    inv_found = 1'b1;
                    inv_idx   = IDX_W'(i);
                end
                // highest clear reference bit
                if (!rb_reg[i])
                begin
                    clr_found = 1'b1;
                    clr_idx   = IDX_W'(i);
                end
                // ranks are distinct, the oldest holds n-1
                if (rk_reg[i] == nm1)
                    lru_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (!is_lru && !is_sc)
        begin
            victim   = nm1;
            ev_valid = fv_reg[nm1];
        end
        else if (inv_found)
        begin
            victim   = inv_idx;
            ev_valid = 1'b0;
        end
        else
        begin
            ev_valid = 1'b1;
            if (is_lru)
                victim = lru_idx;
            else if (clr_found)
                victim = clr_idx;
            else
                victim = nm1;
        end
        if (hit_found)
            ev_valid = 1'b0;
        ev_page      = ev_valid ? EVICT_W'(fp_reg[victim]) : '0;
        hit_rank     = rk_reg[hit_idx];
        sc_clear     = is_sc && !inv_found;
        sc_clear_all = sc_clear && !clr_found;
    end

    // table update
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            fp_next[i] = fp_reg[i];
            fv_next[i] = fv_reg[i];
            rb_next[i] = rb_reg[i];
            rk_next[i] = rk_reg[i];
            if (!hit_found)
            begin
                if (is_lru)
                begin
                    if (IDX_W'(i) == victim)
                    begin
                        fp_next[i] = s1_page_reg;
                        fv_next[i] = 1'b1;
                        rk_next[i] = '0;
                    end
                    else if (fv_reg[i])
                        rk_next[i] = rk_reg[i] + RANK_W'(1);
                end
                else if (i == 0)
                begin
                    fp_next[i] = s1_page_reg;
                    fv_next[i] = 1'b1;
                    rb_next[i] = 1'b0;
                    rk_next[i] = '0;
                end
                else if (IDX_W'(i) <= victim)
                begin
                    fp_next[i] = fp_reg[(i > 0) ? i - 1 : 0];
                    fv_next[i] = fv_reg[(i > 0) ? i - 1 : 0];
                    rb_next[i] = sc_clear_all ? 1'b0 : rb_reg[(i > 0) ? i - 1 : 0];
                    rk_next[i] = rk_reg[(i > 0) ? i - 1 : 0];
                end
                else if (sc_clear && CNT_W'(i) < n_act)
                    rb_next[i] = 1'b0;
            end
            else if (is_lru)
            begin
                if (IDX_W'(i) == hit_idx)
                    rk_next[i] = '0;
                else if (fv_reg[i] && rk_reg[i] < hit_rank)
                    rk_next[i] = rk_reg[i] + RANK_W'(1);
            end
            else if (is_sc && IDX_W'(i) == hit_idx)
                rb_next[i] = 1'b1;
        end

        total_next = total_reg;
        if (!hit_found && total_reg != '1)
            total_next = total_reg + COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RESET;
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLICY: policy_reg <= cfg_data[POLICY_W-1:0];
                REG_FRAMES: frames_reg <= cfg_data[FRAMES_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg    <= '0;
            rb_reg    <= '0;
            total_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
                rk_reg[i] <= '0;
        end
        else if (cfg_clear)
        begin
            fv_reg    <= '0;
            rb_reg    <= '0;
            total_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
                rk_reg[i] <= '0;
        end
        else if (s1_adv)
        begin
            fv_reg    <= fv_next;
            rb_reg    <= rb_next;
            total_reg <= total_next;
            for (int i = 0; i < MAX_FRAMES; i++)
                rk_reg[i] <= rk_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && !cfg_clear)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
                fp_reg[i] <= fp_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_page_reg <= page;
        if (s1_adv)
        begin
            fault_reg <= !hit_found;
            evv_reg   <= ev_valid;
            evp_reg   <= ev_page;
            cnt_reg   <= total_next;
        end
    end

    `PRU_ASSERT(a_evict_needs_fault, !out_valid_reg || !evv_reg || fault_reg, "eviction without fault")
    `PRU_ASSERT(a_evict_page_zero, !out_valid_reg || evv_reg || evp_reg == '0, "evicted page not zero")
    `PRU_ASSERT(a_valid_within_active, $countones(fv_reg) <= int'(n_act), "too many valid frames")
    `PRU_ASSERT_NEXT(a_miss_counts, s1_adv && !hit_found && !cfg_clear, total_reg != '0, "fault not counted")

endmodule
